@@ rtl/gmps_pkg.sv @@
`default_nettype none

package gmps_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 4096;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam int GOLD_W     = 16;
    localparam int SUM_W      = 28;
    localparam int BEST_ROW_W = 5;
    localparam int TIE_W      = 32;

    localparam int NROWS_W = 6;
    localparam int NCOLS_W = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_AW  = 1;

    typedef enum logic [CFG_AW-1:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } cfg_reg_t;

    // write side of the column store
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        logic [SUM_W-1:0] data;
    } gmps_wr_t;

endpackage

`default_nettype wire

@@ rtl/gmps_col_store.sv @@
`default_nettype none

module gmps_col_store (
    input  wire logic                           aclk,
    input  wire gmps_pkg::gmps_wr_t             wr,
    input  wire logic [gmps_pkg::ROW_W-1:0]     rd_addr_a,
    input  wire logic [gmps_pkg::ROW_W-1:0]     rd_addr_b,
    output logic      [gmps_pkg::SUM_W-1:0]     rd_data_a,
    output logic      [gmps_pkg::SUM_W-1:0]     rd_data_b
);

    logic [gmps_pkg::SUM_W-1:0] mem [gmps_pkg::MAX_ROWS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered reads; a same-cycle write to the read address is forwarded
    always_ff @(posedge aclk) begin
        if (wr.en && (wr.addr == rd_addr_a)) begin
            rd_data_a <= wr.data;
        end else begin
            rd_data_a <= mem[rd_addr_a];
        end
        if (wr.en && (wr.addr == rd_addr_b)) begin
            rd_data_b <= wr.data;
        end else begin
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

@@ rtl/grid_max_path_sum_core.sv @@
// The result is on m_* in the cycle after the transfer of the grid's final cell.
// Throughput: one cell per cycle; s_ready drops only while a result waits on m_ready.
// The column store is read one row ahead, so back-to-back cells see fresh neighbor sums.
// Reset (aresetn low, synchronous): position, running maximum and output valid clear,
// num_rows and num_cols return to 1; the column store is not cleared.
`default_nettype none

module grid_max_path_sum_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_we,
    input  wire logic [gmps_pkg::CFG_AW-1:0]         cfg_addr,
    input  wire logic [gmps_pkg::CFG_W-1:0]          cfg_wdata,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [gmps_pkg::GOLD_W-1:0]         s_gold,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [gmps_pkg::SUM_W-1:0]          m_best_total,
    output logic      [gmps_pkg::BEST_ROW_W-1:0]     m_best_row,
    output logic      [gmps_pkg::TIE_W-1:0]          m_tied_rows
);

    logic [gmps_pkg::NROWS_W-1:0]    num_rows_reg;
    logic [gmps_pkg::NCOLS_W-1:0]    num_cols_reg;

    logic [gmps_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [gmps_pkg::COL_W-1:0]      col_reg, col_next;
    logic [gmps_pkg::SUM_W-1:0]      above_reg;
    logic [gmps_pkg::SUM_W-1:0]      best_reg, best_next;
    logic [gmps_pkg::ROW_W-1:0]      best_row_reg, best_row_next;
    logic [gmps_pkg::TIE_W-1:0]      ties_reg, ties_next;
    logic                            m_valid_reg;
    logic [gmps_pkg::SUM_W-1:0]      m_best_total_reg;
    logic [gmps_pkg::BEST_ROW_W-1:0] m_best_row_reg;
    logic [gmps_pkg::TIE_W-1:0]      m_tied_rows_reg;

    logic [gmps_pkg::ROW_W-1:0]      rows_m1;
    logic [gmps_pkg::COL_W-1:0]      cols_m1;
    logic                            last_row, last_col, has_below, finish;
    logic                            s_fire;
    logic [gmps_pkg::SUM_W-1:0]      same_sum, below_sum, pick, sum;
    logic [gmps_pkg::TIE_W-1:0]      row_mask;
    logic [gmps_pkg::ROW_W-1:0]      rd_addr_b;
    gmps_pkg::gmps_wr_t              wr;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // out-of-range counts act as the nearest legal value
    always_comb begin
        if (num_rows_reg == '0) begin
            rows_m1 = '0;
        end else if (32'(num_rows_reg) > gmps_pkg::MAX_ROWS) begin
            rows_m1 = gmps_pkg::ROW_W'(gmps_pkg::MAX_ROWS - 1);
        end else begin
            rows_m1 = gmps_pkg::ROW_W'(num_rows_reg - 1'b1);
        end
        if (num_cols_reg == '0) begin
            cols_m1 = '0;
        end else if (32'(num_cols_reg) > gmps_pkg::MAX_COLS) begin
            cols_m1 = gmps_pkg::COL_W'(gmps_pkg::MAX_COLS - 1);
        end else begin
            cols_m1 = gmps_pkg::COL_W'(num_cols_reg - 1'b1);
        end
    end

    assign last_row  = row_reg >= rows_m1;
    assign last_col  = col_reg >= cols_m1;
    assign has_below = row_reg < rows_m1;
    assign finish    = last_row && last_col;

    always_comb begin
        pick = same_sum;
        if ((row_reg != '0) && (above_reg > pick)) begin
            pick = above_reg;
        end
        if (has_below && (below_sum > pick)) begin
            pick = below_sum;
        end
        if (col_reg == '0) begin
            sum = gmps_pkg::SUM_W'(s_gold);
        end else begin
            sum = gmps_pkg::SUM_W'(s_gold) + pick;
        end
    end

    assign row_mask = gmps_pkg::TIE_W'(1) << row_reg;

    always_comb begin
        best_next     = best_reg;
        best_row_next = best_row_reg;
        ties_next     = ties_reg;
        if (last_col) begin
            if (row_reg == '0) begin
                best_next     = sum;
                best_row_next = '0;
                ties_next     = row_mask;
            end else if (sum > best_reg) begin
                best_next     = sum;
                best_row_next = row_reg;
                ties_next     = row_mask;
            end else if (sum == best_reg) begin
                ties_next     = ties_reg | row_mask;
            end
        end
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (s_fire) begin
            if (last_row) begin
                row_next = '0;
                col_next = last_col ? '0 : col_reg + 1'b1;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    // read ahead at the row of the next cell and at the row below it
    assign rd_addr_b = row_next + 1'b1;
    assign wr        = {s_fire, row_reg, sum};

    gmps_col_store u_store (
        .aclk      (aclk),
        .wr        (wr),
        .rd_addr_a (row_next),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (same_sum),
        .rd_data_b (below_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= gmps_pkg::NROWS_W'(1);
            num_cols_reg <= gmps_pkg::NCOLS_W'(1);
            row_reg      <= '0;
            col_reg      <= '0;
            above_reg    <= '0;
            best_reg     <= '0;
            best_row_reg <= '0;
            ties_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (gmps_pkg::cfg_reg_t'(cfg_addr))
                    gmps_pkg::REG_NUM_ROWS: begin
                        num_rows_reg <= cfg_wdata[gmps_pkg::NROWS_W-1:0];
                    end
                    gmps_pkg::REG_NUM_COLS: begin
                        num_cols_reg <= cfg_wdata[gmps_pkg::NCOLS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            row_reg <= row_next;
            col_reg <= col_next;
            if (s_fire) begin
                above_reg <= same_sum;
                if (finish) begin
                    best_reg     <= '0;
                    best_row_reg <= '0;
                    ties_reg     <= '0;
                end else begin
                    best_reg     <= best_next;
                    best_row_reg <= best_row_next;
                    ties_reg     <= ties_next;
                end
            end
            if (s_fire && finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (s_fire && finish) begin
            m_best_total_reg <= best_next;
            m_best_row_reg   <= gmps_pkg::BEST_ROW_W'(best_row_next);
            m_tied_rows_reg  <= ties_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_total = m_best_total_reg;
    assign m_best_row   = m_best_row_reg;
    assign m_tied_rows  = m_tied_rows_reg;

endmodule

`default_nettype wire

@@ rtl/gmps_checker.sv @@
`default_nettype none

module gmps_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_ready,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [gmps_pkg::SUM_W-1:0]          m_best_total,
    input  wire logic [gmps_pkg::BEST_ROW_W-1:0]     m_best_row,
    input  wire logic [gmps_pkg::TIE_W-1:0]          m_tied_rows
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_best_total)
            && $stable(m_best_row) && $stable(m_tied_rows))
        else $error("result changed while stalled");

    // the reported row is always one of the tied rows
    a_row_tied: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tied_rows[m_best_row])
        else $error("best_row not set in tied_rows");

    // no tied row lies before the reported row
    a_first_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_tied_rows & ((gmps_pkg::TIE_W'(1) << m_best_row) - 1'b1)) == '0))
        else $error("best_row is not the first tied row");

    // a free output slot never blocks input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with free output");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind grid_max_path_sum_core gmps_checker u_gmps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_best_total (m_best_total),
    .m_best_row   (m_best_row),
    .m_tied_rows  (m_tied_rows)
);

`default_nettype wire

@@ bench/grid_max_path_sum_core_test.sv @@
`timescale 1ns / 100ps

module grid_max_path_sum_core_test;

    localparam int MAX_ROWS   = gmps_pkg::MAX_ROWS;
    localparam int MAX_COLS   = gmps_pkg::MAX_COLS;
    localparam int ROW_W      = gmps_pkg::ROW_W;
    localparam int COL_W      = gmps_pkg::COL_W;
    localparam int GOLD_W     = gmps_pkg::GOLD_W;
    localparam int SUM_W      = gmps_pkg::SUM_W;
    localparam int BEST_ROW_W = gmps_pkg::BEST_ROW_W;
    localparam int TIE_W      = gmps_pkg::TIE_W;
    localparam int NROWS_W    = gmps_pkg::NROWS_W;
    localparam int NCOLS_W    = gmps_pkg::NCOLS_W;
    localparam int CFG_W      = gmps_pkg::CFG_W;
    localparam int CFG_AW     = gmps_pkg::CFG_AW;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_CELLS   = 400;
    localparam int RAND_GRIDS   = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic [SUM_W-1:0]      total;
        logic [BEST_ROW_W-1:0] row;
        logic [TIE_W-1:0]      ties;
    } grid_result_t;

    // one directed grid: register values, leading cells, then ramp or fill
    typedef struct packed {
        logic [CFG_W-1:0]      rows_w;
        logic [CFG_W-1:0]      cols_w;
        logic [0:5][15:0]      head;
        logic [2:0]            head_n;
        logic                  ramp;
        logic [GOLD_W-1:0]     fill;
        logic                  typed;
        grid_result_t          want;
    } grid_case_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_AW-1:0]     cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [GOLD_W-1:0]     s_gold;
    logic                  m_valid;
    logic                  m_ready;
    logic [SUM_W-1:0]      m_best_total;
    logic [BEST_ROW_W-1:0] m_best_row;
    logic [TIE_W-1:0]      m_tied_rows;

    grid_max_path_sum_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_gold       (s_gold),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_total (m_best_total),
        .m_best_row   (m_best_row),
        .m_tied_rows  (m_tied_rows)
    );

    // path-sum predictor state
    logic [NROWS_W-1:0]    rows_reg = NROWS_W'(1);
    logic [NCOLS_W-1:0]    cols_reg = NCOLS_W'(1);
    logic [SUM_W-1:0]      prev_col [0:MAX_ROWS-1];
    logic [SUM_W-1:0]      above_sum = '0;
    logic [ROW_W-1:0]      row_pos = '0;
    logic [COL_W-1:0]      col_pos = '0;
    logic [SUM_W-1:0]      best_sum = '0;
    logic [BEST_ROW_W-1:0] best_at = '0;
    logic [TIE_W-1:0]      tie_mask = '0;

    grid_result_t          pending_results [$];
    logic                  use_typed = 1'b0;
    grid_result_t          typed_result;

    int                    idle_mode = 0;
    logic                  stall_request = 1'b0;
    logic                  stall_held = 1'b0;
    int                    cells_sent = 0;
    int                    grids_done = 0;
    int                    results_seen = 0;
    int                    mismatches = 0;
    int                    cycle_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int r = 0; r < MAX_ROWS; r++) prev_col[r] = '0;
    end

    function automatic int rows_in_use(input logic [NROWS_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_ROWS) return MAX_ROWS;
        return int'(v);
    endfunction

    function automatic int cols_in_use(input logic [NCOLS_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_COLS) return MAX_COLS;
        return int'(v);
    endfunction

    // fold one accepted cell into the running path sums
    task automatic fold_cell(input logic [GOLD_W-1:0] v);
        int           rows;
        int           cols;
        int           r;
        logic         last_row;
        logic         last_col;
        logic [SUM_W-1:0] same;
        logic [SUM_W-1:0] pick;
        logic [SUM_W-1:0] s;
        grid_result_t res;
        rows = rows_in_use(rows_reg);
        cols = cols_in_use(cols_reg);
        r = row_pos;
        last_row = (r >= rows - 1);
        last_col = (col_pos >= cols - 1);
        same = prev_col[r];
        if (col_pos == 0) begin
            s = SUM_W'(v);
        end else begin
            pick = same;
            if (r > 0 && above_sum > pick) pick = above_sum;
            if (r + 1 < rows && prev_col[r + 1] > pick) pick = prev_col[r + 1];
            s = SUM_W'(v) + pick;
        end
        above_sum = same;
        prev_col[r] = s;
        if (last_col) begin
            if (r == 0) begin
                best_sum = s;
                best_at = '0;
                tie_mask = 32'd1;
            end else if (s > best_sum) begin
                best_sum = s;
                best_at = BEST_ROW_W'(r);
                tie_mask = 32'd1 << r;
            end else if (s == best_sum) begin
                tie_mask |= 32'd1 << r;
            end
        end
        if (last_row) begin
            row_pos = '0;
            if (last_col) begin
                res = {best_sum, best_at, tie_mask};
                if (use_typed) begin
                    res = typed_result;
                    use_typed = 1'b0;
                end
                pending_results.push_back(res);
                grids_done++;
                col_pos = '0;
                best_sum = '0;
                best_at = '0;
                tie_mask = '0;
            end else begin
                col_pos++;
            end
        end else begin
            row_pos = ROW_W'(r + 1);
        end
    endtask

    function automatic int draw_gap();
        case (idle_mode)
            0: return ($urandom_range(99) < 11) ? $urandom_range(1, 3) : 0;
            1: return ($urandom_range(99) < 47) ? $urandom_range(1, 4) : 0;
            default: return 0;
        endcase
    endfunction

    // offer one cell and wait for its transfer
    task automatic push_cell(input logic [GOLD_W-1:0] v);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_gold <= v;
        do @(posedge aclk); while (!s_ready);
        fold_cell(v);
        cells_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait until every expected result has arrived and the block is quiet
    task automatic settle_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] rows_w, input logic [CFG_W-1:0] cols_w);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= gmps_pkg::REG_NUM_ROWS;
        cfg_wdata <= rows_w;
        @(negedge aclk);
        cfg_addr <= gmps_pkg::REG_NUM_COLS;
        cfg_wdata <= cols_w;
        @(negedge aclk);
        cfg_we <= 1'b0;
        rows_reg = rows_w[NROWS_W-1:0];
        cols_reg = cols_w[NCOLS_W-1:0];
    endtask

    function automatic logic [GOLD_W-1:0] draw_gold(input int style);
        int p;
        p = $urandom_range(9);
        case (style)
            0: return GOLD_W'($urandom);
            1: return GOLD_W'($urandom_range(3));
            default: begin
                if (p < 5) return GOLD_W'($urandom);
                if (p < 8) return GOLD_W'($urandom_range(3));
                if (p == 8) return 16'hFFFF;
                return '0;
            end
        endcase
    endfunction

    task automatic play_grids(input int cells, input int count);
        int style;
        for (int g = 0; g < count; g++) begin
            style = $urandom_range(2);
            for (int k = 0; k < cells; k++) push_cell(draw_gold(style));
        end
    endtask

    function automatic grid_case_t mk_case(
        input int rows_w, input int cols_w,
        input logic [0:5][15:0] head, input int head_n, input int ramp,
        input int fill, input int typed,
        input int total, input int row,
        input logic [TIE_W-1:0] ties);
        grid_case_t c;
        c.rows_w = CFG_W'(rows_w);
        c.cols_w = CFG_W'(cols_w);
        c.head = head;
        c.head_n = 3'(head_n);
        c.ramp = (ramp != 0);
        c.fill = GOLD_W'(fill);
        c.typed = (typed != 0);
        c.want = {SUM_W'(total), BEST_ROW_W'(row), ties};
        return c;
    endfunction

    // output side: random backpressure plus one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request && !stall_held) begin
                stall_held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                case (idle_mode)
                    0: m_ready <= ($urandom_range(99) >= 47);
                    1: m_ready <= ($urandom_range(99) >= 11);
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        grid_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: expected none actual %0d/%0d/%h",
                         $time, m_best_total, m_best_row, m_tied_rows);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (m_best_total !== want.total) begin
                    mismatches++;
                    $display("%0t best_total: expected %0d actual %0d",
                             $time, want.total, m_best_total);
                end
                if (m_best_row !== want.row) begin
                    mismatches++;
                    $display("%0t best_row: expected %0d actual %0d",
                             $time, want.row, m_best_row);
                end
                if (m_tied_rows !== want.ties) begin
                    mismatches++;
                    $display("%0t tied_rows: expected %h actual %h",
                             $time, want.ties, m_tied_rows);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout, %0d results still expected", $time,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        grid_case_t       plan [0:12];
        int               n;
        int               p;
        int               rows;
        int               cols;
        int               rand_cells;
        int               rand_grids;
        int               reps;
        logic [CFG_W-1:0] rows_w;
        logic [CFG_W-1:0] cols_w;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = gmps_pkg::REG_NUM_ROWS;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_gold = '0;

        // head cells run in arrival order, rows inside columns
        plan[0]  = mk_case(1, 1, {16'd0, 80'd0}, 1, 0, 0, 1, 0, 0, 32'h1);
        plan[1]  = mk_case(1, 1, 96'd0, 0, 0, 'hFFFF, 1, 65535, 0, 32'h1);
        plan[2]  = mk_case(0, 0, {16'd5, 80'd0}, 1, 0, 0, 1, 5, 0, 32'h1);
        plan[3]  = mk_case(3, 1, {16'd7, 16'd9, 16'd9, 48'd0}, 3, 0, 0, 1, 9, 1, 32'h6);
        plan[4]  = mk_case(3, 2, {16'd1, 16'd2, 16'd3, 16'd5, 16'd5, 16'd4}, 6, 0, 0,
                           1, 8, 1, 32'h2);
        plan[5]  = mk_case(4, 3, 96'd0, 0, 0, 0, 1, 0, 0, 32'hF);
        plan[6]  = mk_case(32, 1, 96'd0, 0, 1, 0, 1, 31, 31, 32'h8000_0000);
        plan[7]  = mk_case(63, 1, 96'd0, 0, 0, 'hFFFF, 1, 65535, 0, 32'hFFFF_FFFF);
        plan[8]  = mk_case(32, 4, 96'd0, 0, 0, 'hFFFF, 1, 262140, 0, 32'hFFFF_FFFF);
        plan[9]  = mk_case('h1FC2, 1, {16'd3, 16'd3, 64'd0}, 2, 0, 0, 1, 3, 0, 32'h3);
        plan[10] = mk_case(2, 3, {16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0}, 6,
                           0, 0, 0, 0, 0, 0);
        plan[11] = mk_case(5, 7, 96'd0, 0, 1, 0, 0, 0, 0, 0);
        // single row, every cell at its top value
        plan[12] = mk_case(0, 8, 96'd0, 0, 0, 'hFFFF, 1, 524280, 0, 32'h1);

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // first grid runs on the reset values of the registers
        for (int i = 0; i <= 12; i++) begin
            settle_idle();
            if (i > 0) configure(plan[i].rows_w, plan[i].cols_w);
            use_typed = plan[i].typed;
            typed_result = plan[i].want;
            n = rows_in_use(plan[i].rows_w[NROWS_W-1:0]) * cols_in_use(plan[i].cols_w);
            for (int k = 0; k < n; k++) begin
                if (k < plan[i].head_n) push_cell(plan[i].head[k]);
                else if (plan[i].ramp) push_cell(k[15:0]);
                else push_cell(plan[i].fill);
            end
            release_input();
        end

        rand_cells = 0;
        rand_grids = 0;
        while (rand_cells < RAND_CELLS || rand_grids < RAND_GRIDS) begin
            idle_mode = (rand_cells < RAND_CELLS / 3) ? 0 :
                        (rand_cells < 2 * RAND_CELLS / 3) ? 1 : 2;
            settle_idle();
            if (idle_mode == 2 && !stall_request) begin
                // tiny grids back to back while the output is held off
                configure(CFG_W'(2), CFG_W'(1));
                stall_request = 1'b1;
                play_grids(2, 8);
                release_input();
                rand_cells += 16;
                rand_grids += 8;
                continue;
            end
            p = $urandom_range(99);
            if (p < 60) rows = $urandom_range(1, 4);
            else if (p < 88) rows = $urandom_range(5, 10);
            else if (p < 95) rows = $urandom_range(11, 32);
            else if (p < 98) rows = 0;
            else rows = $urandom_range(33, 63);
            p = $urandom_range(99);
            if (p < 60) cols = $urandom_range(1, 3);
            else if (p < 90) cols = $urandom_range(4, 6);
            else if (p < 97) cols = $urandom_range(7, 16);
            else cols = 0;
            rows_w = CFG_W'(rows);
            if ($urandom_range(3) == 0) rows_w[CFG_W-1:NROWS_W] = (CFG_W - NROWS_W)'($urandom);
            cols_w = CFG_W'(cols);
            configure(rows_w, cols_w);
            n = rows_in_use(rows_w[NROWS_W-1:0]) * cols_in_use(cols_w);
            reps = $urandom_range(1, 3);
            play_grids(n, reps);
            release_input();
            rand_cells += n * reps;
            rand_grids += reps;
        end

        settle_idle();
        repeat (10) @(posedge aclk);
        $display("covered %0d cells in %0d grids, %0d results compared",
                 cells_sent, grids_done, results_seen);
        $display("register extremes, clamped sizes, ties and a long output hold-off included");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ grid_max_path_sum_core.f @@
rtl/gmps_pkg.sv
rtl/gmps_col_store.sv
rtl/grid_max_path_sum_core.sv
rtl/gmps_checker.sv
bench/grid_max_path_sum_core_test.sv
